### sv/cmae_pkg.sv
// ----------------------------------------------------------------------------
// cmae_pkg
// Shared types, constants, microcode and calendar functions for the calendar
// minute add and elapsed unit.
// ----------------------------------------------------------------------------
package cmae_pkg;

    localparam int unsigned PC_W = 4;

    localparam logic [10:0] MAX_ADD       = 11'd1439;
    localparam logic [10:0] MIN_PER_HOUR  = 11'd60;
    localparam logic [5:0]  HOUR_PER_DAY  = 6'd24;
    localparam logic [3:0]  MONTHS        = 4'd12;
    localparam logic [15:0] ELAPSED_EARLY = 16'hffff;
    localparam logic [15:0] ELAPSED_LAST  = 16'h7ffe;

    typedef struct packed {
        logic        action;
        logic [11:0] start_year;
        logic [3:0]  start_month;
        logic [4:0]  start_day;
        logic [4:0]  start_hour;
        logic [5:0]  start_minute;
        logic [11:0] target_year;
        logic [3:0]  target_month;
        logic [4:0]  target_day;
        logic [4:0]  target_hour;
        logic [5:0]  target_minute;
        logic [10:0] add_count;
    } req_t;

    typedef struct packed {
        logic [11:0]        out_year;
        logic [3:0]         out_month;
        logic [4:0]         out_day;
        logic [4:0]         out_hour;
        logic [5:0]         out_minute;
        logic signed [15:0] elapsed_minutes;
    } rsp_t;

    typedef struct packed {
        logic [11:0] yr;
        logic [3:0]  mon;
        logic [4:0]  dom;
        logic [5:0]  hr;
        logic [10:0] mn;
    } stamp_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ADD,
        OP_SUB60,
        OP_SUB24,
        OP_DAYINC,
        OP_CMP,
        OP_TICK,
        OP_DONE
    } op_t;

    typedef enum logic [2:0] {
        CD_NEVER,
        CD_ALWAYS,
        CD_ELAPSED,
        CD_MN_GE60,
        CD_NO_DAY,
        CD_HR_GE24,
        CD_DECIDED,
        CD_RUN
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic load;
        op_t  op;
    } dp_ctrl_t;

    typedef struct packed {
        logic elapsed;
        logic mn_ge60;
        logic no_day;
        logic hr_ge24;
        logic decided;
        logic run;
    } dp_status_t;

    localparam logic [PC_W-1:0] PC_START = 4'd0;
    localparam logic [PC_W-1:0] PC_ADD   = 4'd1;
    localparam logic [PC_W-1:0] PC_MIN   = 4'd2;
    localparam logic [PC_W-1:0] PC_CARRY = 4'd3;
    localparam logic [PC_W-1:0] PC_HOUR  = 4'd4;
    localparam logic [PC_W-1:0] PC_DAY   = 4'd5;
    localparam logic [PC_W-1:0] PC_CMP   = 4'd6;
    localparam logic [PC_W-1:0] PC_TICK  = 4'd7;
    localparam logic [PC_W-1:0] PC_DONE  = 4'd8;

    function automatic uword_t ucode(logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            PC_START: w = '{op: OP_NOP,    cond: CD_ELAPSED, target: PC_CMP};
            PC_ADD:   w = '{op: OP_ADD,    cond: CD_NEVER,   target: PC_START};
            PC_MIN:   w = '{op: OP_SUB60,  cond: CD_MN_GE60, target: PC_MIN};
            PC_CARRY: w = '{op: OP_NOP,    cond: CD_NO_DAY,  target: PC_DONE};
            PC_HOUR:  w = '{op: OP_SUB24,  cond: CD_HR_GE24, target: PC_HOUR};
            PC_DAY:   w = '{op: OP_DAYINC, cond: CD_ALWAYS,  target: PC_DONE};
            PC_CMP:   w = '{op: OP_CMP,    cond: CD_DECIDED, target: PC_DONE};
            PC_TICK:  w = '{op: OP_TICK,   cond: CD_RUN,     target: PC_TICK};
            default:  w = '{op: OP_DONE,   cond: CD_NEVER,   target: PC_DONE};
        endcase
        return w;
    endfunction

    function automatic logic mult25(logic [9:0] v);
        logic r;
        r = 1'b0;
        for (int k = 0; k < 41; k++)
        begin
            if (v == 10'(k * 25))
            begin
                r = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic is_leap(logic [11:0] y);
        logic by100;
        logic by400;
        by100 = mult25(y[11:2]);
        by400 = (y[3:0] == 4'd0) && mult25({2'b00, y[11:4]});
        return (y[1:0] == 2'd0) && (!by100 || by400);
    endfunction

    function automatic logic [4:0] month_len(logic [11:0] y, logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd2:                      len = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic stamp_t day_inc(stamp_t s);
        stamp_t     r;
        logic [5:0] d;
        logic [4:0] m;
        r = s;
        d = {1'b0, s.dom} + 6'd1;
        m = {1'b0, s.mon} + 5'd1;
        if (d > {1'b0, month_len(s.yr, s.mon)})
        begin
            r.dom = 5'd1;
            if (m > {1'b0, MONTHS})
            begin
                r.mon = 4'd1;
                r.yr  = s.yr + 12'd1;
            end
            else
            begin
                r.mon = m[3:0];
            end
        end
        else
        begin
            r.dom = d[4:0];
        end
        return r;
    endfunction

    function automatic stamp_t tick(stamp_t s);
        stamp_t      r;
        logic [10:0] m;
        logic [5:0]  h;
        r = s;
        m = s.mn + 11'd1;
        h = s.hr + 6'd1;
        if (m >= MIN_PER_HOUR)
        begin
            r.mn = m - MIN_PER_HOUR;
            if (h >= HOUR_PER_DAY)
            begin
                r.hr = h - HOUR_PER_DAY;
                r    = day_inc(r);
            end
            else
            begin
                r.hr = h;
            end
        end
        else
        begin
            r.mn = m;
        end
        return r;
    endfunction

endpackage

### sv/cmae_datapath.sv
// ----------------------------------------------------------------------------
// cmae_datapath
// Working date register, elapsed counter and the operations that the
// microcode steps through.
// ----------------------------------------------------------------------------
module cmae_datapath
    import cmae_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_ctrl_t   ctrl,
    input  req_t       req,
    output dp_status_t status,
    output rsp_t       rsp
);

    req_t        req_reg;
    stamp_t      w_reg;
    stamp_t      w_next;
    logic        carry_reg;
    logic        carry_next;
    logic [15:0] el_reg;
    logic [15:0] el_next;

    stamp_t      start_s;
    stamp_t      target_s;
    stamp_t      tick_s;
    logic [10:0] add_n;
    logic        match;
    logic        decided;
    logic [15:0] cmp_value;

    always_comb
    begin
        start_s  = '{yr: req.start_year, mon: req.start_month, dom: req.start_day,
                     hr: {1'b0, req.start_hour}, mn: {5'd0, req.start_minute}};
        target_s = '{yr: req_reg.target_year, mon: req_reg.target_month,
                     dom: req_reg.target_day, hr: {1'b0, req_reg.target_hour},
                     mn: {5'd0, req_reg.target_minute}};
        add_n    = (req_reg.add_count > MAX_ADD) ? MAX_ADD : req_reg.add_count;
        tick_s   = tick(w_reg);
        match    = (tick_s == target_s);
    end

    // decide early cases: target earlier, or same hour
    always_comb
    begin
        decided   = 1'b1;
        cmp_value = ELAPSED_EARLY;
        priority if (target_s.yr != w_reg.yr)
        begin
            decided = target_s.yr < w_reg.yr;
        end
        else if (target_s.mon != w_reg.mon)
        begin
            decided = target_s.mon < w_reg.mon;
        end
        else if (target_s.dom != w_reg.dom)
        begin
            decided = target_s.dom < w_reg.dom;
        end
        else if (target_s.hr != w_reg.hr)
        begin
            decided = target_s.hr < w_reg.hr;
        end
        else if (target_s.mn >= w_reg.mn)
        begin
            cmp_value = {5'd0, target_s.mn - w_reg.mn};
        end
        else
        begin
            cmp_value = ELAPSED_EARLY;
        end
    end

    always_comb
    begin
        w_next     = w_reg;
        carry_next = carry_reg;
        el_next    = el_reg;
        if (ctrl.load)
        begin
            w_next     = start_s;
            carry_next = 1'b0;
            el_next    = 16'd0;
        end
        else
        begin
            unique case (ctrl.op)
                OP_ADD:
                begin
                    w_next.mn = w_reg.mn + add_n;
                end
                OP_SUB60:
                begin
                    if (w_reg.mn >= MIN_PER_HOUR)
                    begin
                        w_next.mn  = w_reg.mn - MIN_PER_HOUR;
                        w_next.hr  = w_reg.hr + 6'd1;
                        carry_next = 1'b1;
                    end
                end
                OP_SUB24:
                begin
                    if (w_reg.hr >= HOUR_PER_DAY)
                    begin
                        w_next.hr = w_reg.hr - HOUR_PER_DAY;
                    end
                end
                OP_DAYINC:
                begin
                    w_next = day_inc(w_reg);
                end
                OP_CMP:
                begin
                    if (decided)
                    begin
                        el_next = cmp_value;
                    end
                end
                OP_TICK:
                begin
                    w_next  = tick_s;
                    el_next = el_reg + 16'd1;
                end
                default:
                begin
                    w_next = w_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg   <= '0;
            w_reg     <= '0;
            carry_reg <= 1'b0;
            el_reg    <= '0;
        end
        else
        begin
            if (ctrl.load)
            begin
                req_reg <= req;
            end
            w_reg     <= w_next;
            carry_reg <= carry_next;
            el_reg    <= el_next;
        end
    end

    always_comb
    begin
        status.elapsed = req_reg.action;
        status.mn_ge60 = w_reg.mn >= MIN_PER_HOUR;
        status.hr_ge24 = w_reg.hr >= HOUR_PER_DAY;
        status.no_day  = !carry_reg || (w_reg.hr < HOUR_PER_DAY);
        status.decided = decided;
        status.run     = !match && (el_reg != ELAPSED_LAST);
    end

    always_comb
    begin
        if (req_reg.action)
        begin
            rsp.out_year   = req_reg.start_year;
            rsp.out_month  = req_reg.start_month;
            rsp.out_day    = req_reg.start_day;
            rsp.out_hour   = req_reg.start_hour;
            rsp.out_minute = req_reg.start_minute;
        end
        else
        begin
            rsp.out_year   = w_reg.yr;
            rsp.out_month  = w_reg.mon;
            rsp.out_day    = w_reg.dom;
            rsp.out_hour   = w_reg.hr[4:0];
            rsp.out_minute = w_reg.mn[5:0];
        end
        rsp.elapsed_minutes = el_reg;
    end

endmodule

### sv/calendar_minute_add_and_elapsed_unit.sv
// ----------------------------------------------------------------------------
// calendar_minute_add_and_elapsed_unit
// Adds up to 1439 minutes to a calendar date and time, or counts the minutes
// from a start date and time to a target.
// ----------------------------------------------------------------------------
// The unit takes one request word at a time and holds req_stall high until
// its result is loaded into the output register. A small microcode program
// runs the work one step per cycle. Add mode adds the minutes, runs the loop
// that removes whole hours from the minute sum and, after a day carry, the
// loop that brings the hour below 24 before advancing the day. Elapsed mode
// ends at the compare step when the target is earlier or in the same hour,
// and otherwise counts each minute, up to 32767 minutes, since the tick step
// advances the working date by one minute per cycle. A result whose output
// register is still full and stalled waits at the last step. The next request
// word can be taken in the cycle after the result is loaded, while that result
// waits in the output register.
module calendar_minute_add_and_elapsed_unit
    import cmae_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            busy_reg;
    logic            busy_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    rsp_t            rsp_reg;

    uword_t          uw;
    dp_ctrl_t        ctrl;
    dp_status_t      status;
    rsp_t            dp_rsp;
    logic            accept;
    logic            done_fire;
    logic            jump;

    assign uw        = ucode(pc_reg);
    assign accept    = req_valid && !busy_reg;
    assign done_fire = busy_reg && (uw.op == OP_DONE) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        unique case (uw.cond)
            CD_NEVER:   jump = 1'b0;
            CD_ALWAYS:  jump = 1'b1;
            CD_ELAPSED: jump = status.elapsed;
            CD_MN_GE60: jump = status.mn_ge60;
            CD_NO_DAY:  jump = status.no_day;
            CD_HR_GE24: jump = status.hr_ge24;
            CD_DECIDED: jump = status.decided;
            CD_RUN:     jump = status.run;
            default:    jump = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next        = pc_reg;
        busy_next      = busy_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            pc_next   = PC_START;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (uw.op == OP_DONE)
            begin
                if (done_fire)
                begin
                    busy_next      = 1'b0;
                    rsp_valid_next = 1'b1;
                end
            end
            else if (jump)
            begin
                pc_next = uw.target;
            end
            else
            begin
                pc_next = pc_reg + PC_W'(1);
            end
        end
    end

    always_comb
    begin
        ctrl.load = accept;
        ctrl.op   = busy_reg ? uw.op : OP_NOP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_START;
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            busy_reg      <= busy_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_fire)
        begin
            rsp_reg <= dp_rsp;
        end
    end

    cmae_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .req    (req),
        .status (status),
        .rsp    (dp_rsp)
    );

    assign req_stall = busy_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
